// File: rtl/euler_pose_point_transform_defines.svh
// Assertion macros shared by the point transform RTL.
`ifndef EULER_POSE_POINT_TRANSFORM_DEFINES_SVH
`define EULER_POSE_POINT_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define EPPT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eppt assertion failed");
`define EPPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eppt assertion failed");
`else
`define EPPT_ASSERT_IMPL(lbl, ante, cons)
`define EPPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/eppt_pkg.sv
// Constants, types and arithmetic helpers for the Euler pose point transform.
package eppt_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned ANG_W = 16;
  localparam int unsigned POS_W = 32;
  localparam int unsigned CW = 34;
  localparam int unsigned TW = 32;

  localparam logic signed [POS_W-1:0] FIXED_HEIGHT_RST = 32'sd104858;
  localparam logic signed [CW:0] Q30_PI = 35'sd3373259426;
  localparam logic signed [CW:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [63:0] Q30_HALF = 64'sd536870912;
  localparam logic signed [TW:0] Q30_ONE = 33'sd1073741824;

  // Operand fields carried alongside the angle pipeline
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
    logic signed [POS_W-1:0] lz;
  } carry_t;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 product, rounded half up, floor shift
  function automatic logic signed [TW-1:0] mul30(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    logic signed [63:0] p;
    p = (64'(a) * 64'(b)) + Q30_HALF;
    return TW'(p >>> 30);
  endfunction

  // Clamp a matrix entry to [-1, 1] in Q30
  function automatic logic signed [TW-1:0] clamp1(input logic signed [TW:0] v);
    logic signed [TW-1:0] r;
    if (v > Q30_ONE) r = TW'(Q30_ONE);
    else if (v < -Q30_ONE) r = TW'(-Q30_ONE);
    else r = TW'(v);
    return r;
  endfunction

endpackage

// File: rtl/euler_pose_point_transform.sv
// Pipelined Euler pose point transform: CORDIC sine/cosine, rotation, translation.
//
//  channel | ports                       | handshake
//  --------+-----------------------------+-------------------------------
//  input   | in_* fields                 | start && !busy (busy stays low)
//  result  | out_* fields                | out_valid strobe, one cycle
//  config  | cfg_fixed_height            | cfg_valid && cfg_ready
//
// One transaction enters per cycle; each result passes through one register stage
// per CORDIC iteration plus fold, sign, two matrix multiply, clamp, point multiply,
// sum and output stages.
// Reset clears the valid bits and loads the fixed height with 1.6.
// Nothing in the pipeline ever stalls.
`include "euler_pose_point_transform_defines.svh"
module euler_pose_point_transform #(
  parameter int unsigned CORDIC_STEPS = eppt_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [31:0] in_pose_z,
  input  logic signed [15:0] in_roll,
  input  logic signed [15:0] in_pitch,
  input  logic signed [15:0] in_yaw,
  input  logic signed [31:0] in_local_x,
  input  logic signed [31:0] in_local_y,
  input  logic signed [31:0] in_local_z,
  output logic        out_valid,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y,
  output logic signed [31:0] out_world_z,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic signed [31:0] cfg_fixed_height
);

  localparam int unsigned CW = eppt_pkg::CW;
  localparam int unsigned TW = eppt_pkg::TW;
  localparam int unsigned N = (CORDIC_STEPS < eppt_pkg::ATAN_LEN) ?
                              CORDIC_STEPS : eppt_pkg::ATAN_LEN;
  localparam int unsigned LAT = N + 8;
  localparam logic signed [CW-1:0] ZB = CW'(2 * eppt_pkg::atan_q30(N - 1));

  logic [LAT-1:0] v_r;
  logic signed [31:0] fh_r;
  eppt_pkg::carry_t carry_r [0:N+6];

  logic signed [CW-1:0] cx_r [0:N][0:2];
  logic signed [CW-1:0] cy_r [0:N][0:2];
  logic signed [CW-1:0] cz_r [0:N][0:2];
  logic                 neg_r [0:N][0:2];

  logic signed [CW:0] zin [0:2];
  logic signed [15:0] ang [0:2];

  // sine and cosine: index 0 roll, 1 pitch, 2 yaw
  logic signed [TW-1:0] s_r [0:2];
  logic signed [TW-1:0] c_r [0:2];

  logic signed [TW-1:0] cysp_r, sysp_r, sycr_r, cycr_r, sysr_r, cysr_r, cycp_r, sycp_r;
  logic signed [TW-1:0] sr1_r, cr1_r;
  logic signed [TW-1:0] a01_r, a02_r, a11_r, a12_r;
  logic signed [TW-1:0] b01_r, b02_r, b11_r, b12_r, r00a_r, r10a_r;
  logic signed [TW-1:0] r00_r, r01_r, r02_r, r10_r, r11_r, r12_r;
  logic signed [63:0] p00_r, p01_r, p02_r, p10_r, p11_r, p12_r;
  logic signed [65:0] sx_r, sy_r;
  logic signed [36:0] wx, wy;
  logic signed [65:0] rx, ry;
  logic sat_x, sat_y;
  logic signed [31:0] wx_c, wy_c;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign ang[0] = in_roll;
  assign ang[1] = in_pitch;
  assign ang[2] = in_yaw;

  // Hold the fixed height register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_r <= eppt_pkg::FIXED_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      fh_r <= cfg_fixed_height;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], start && !busy};
    end
  end

  // Carry the position and point along the pipeline
  always_ff @(posedge clk) begin
    carry_r[0] <= '{px: in_pose_x, py: in_pose_y, lx: in_local_x,
                    ly: in_local_y, lz: in_local_z};
    for (int k = 1; k <= N + 6; k++) begin
      carry_r[k] <= carry_r[k-1];
    end
  end

  // Widen angles to Q30 and fold into +-pi/2
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      zin[a] = {{2{ang[a][15]}}, ang[a], 17'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      cx_r[0][a] <= eppt_pkg::CORDIC_GAIN;
      cy_r[0][a] <= '0;
      if (zin[a] > eppt_pkg::Q30_HALF_PI) begin
        cz_r[0][a]  <= CW'(zin[a] - eppt_pkg::Q30_PI);
        neg_r[0][a] <= 1'b1;
      end else if (zin[a] < -eppt_pkg::Q30_HALF_PI) begin
        cz_r[0][a]  <= CW'(zin[a] + eppt_pkg::Q30_PI);
        neg_r[0][a] <= 1'b1;
      end else begin
        cz_r[0][a]  <= CW'(zin[a]);
        neg_r[0][a] <= 1'b0;
      end
    end
  end

  // One CORDIC rotation per stage
  for (genvar k = 0; k < N; k++) begin : g_cordic
    localparam logic signed [CW-1:0] AT = eppt_pkg::atan_q30(k);
    always_ff @(posedge clk) begin
      for (int a = 0; a < 3; a++) begin
        neg_r[k+1][a] <= neg_r[k][a];
        if (!cz_r[k][a][CW-1]) begin
          cx_r[k+1][a] <= cx_r[k][a] - (cy_r[k][a] >>> k);
          cy_r[k+1][a] <= cy_r[k][a] + (cx_r[k][a] >>> k);
          cz_r[k+1][a] <= cz_r[k][a] - AT;
        end else begin
          cx_r[k+1][a] <= cx_r[k][a] + (cy_r[k][a] >>> k);
          cy_r[k+1][a] <= cy_r[k][a] - (cx_r[k][a] >>> k);
          cz_r[k+1][a] <= cz_r[k][a] + AT;
        end
      end
    end
  end

  // Apply the fold sign
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s_r[a] <= neg_r[N][a] ? TW'(-cy_r[N][a]) : TW'(cy_r[N][a]);
      c_r[a] <= neg_r[N][a] ? TW'(-cx_r[N][a]) : TW'(cx_r[N][a]);
    end
  end

  // First products of the rotation
  always_ff @(posedge clk) begin
    cysp_r <= eppt_pkg::mul30(c_r[2], s_r[1]);
    sysp_r <= eppt_pkg::mul30(s_r[2], s_r[1]);
    sycr_r <= eppt_pkg::mul30(s_r[2], c_r[0]);
    cycr_r <= eppt_pkg::mul30(c_r[2], c_r[0]);
    sysr_r <= eppt_pkg::mul30(s_r[2], s_r[0]);
    cysr_r <= eppt_pkg::mul30(c_r[2], s_r[0]);
    cycp_r <= eppt_pkg::mul30(c_r[2], c_r[1]);
    sycp_r <= eppt_pkg::mul30(s_r[2], c_r[1]);
    sr1_r  <= s_r[0];
    cr1_r  <= c_r[0];
  end

  // Second products with the roll terms
  always_ff @(posedge clk) begin
    a01_r  <= eppt_pkg::mul30(cysp_r, sr1_r);
    a02_r  <= eppt_pkg::mul30(cysp_r, cr1_r);
    a11_r  <= eppt_pkg::mul30(sysp_r, sr1_r);
    a12_r  <= eppt_pkg::mul30(sysp_r, cr1_r);
    b01_r  <= sycr_r;
    b02_r  <= sysr_r;
    b11_r  <= cycr_r;
    b12_r  <= cysr_r;
    r00a_r <= cycp_r;
    r10a_r <= sycp_r;
  end

  // Combine and clamp the matrix entries
  always_ff @(posedge clk) begin
    r00_r <= eppt_pkg::clamp1((TW+1)'(r00a_r));
    r01_r <= eppt_pkg::clamp1((TW+1)'(a01_r) - (TW+1)'(b01_r));
    r02_r <= eppt_pkg::clamp1((TW+1)'(a02_r) + (TW+1)'(b02_r));
    r10_r <= eppt_pkg::clamp1((TW+1)'(r10a_r));
    r11_r <= eppt_pkg::clamp1((TW+1)'(a11_r) + (TW+1)'(b11_r));
    r12_r <= eppt_pkg::clamp1((TW+1)'(a12_r) - (TW+1)'(b12_r));
  end

  // Multiply by the body point
  always_ff @(posedge clk) begin
    p00_r <= 64'(r00_r) * 64'(carry_r[N+4].lx);
    p01_r <= 64'(r01_r) * 64'(carry_r[N+4].ly);
    p02_r <= 64'(r02_r) * 64'(carry_r[N+4].lz);
    p10_r <= 64'(r10_r) * 64'(carry_r[N+4].lx);
    p11_r <= 64'(r11_r) * 64'(carry_r[N+4].ly);
    p12_r <= 64'(r12_r) * 64'(carry_r[N+4].lz);
  end

  // Sum the row products
  always_ff @(posedge clk) begin
    sx_r <= 66'(p00_r) + 66'(p01_r) + 66'(p02_r);
    sy_r <= 66'(p10_r) + 66'(p11_r) + 66'(p12_r);
  end

  // Round, translate and saturate
  always_comb begin
    rx = (sx_r + 66'(eppt_pkg::Q30_HALF)) >>> 30;
    ry = (sy_r + 66'(eppt_pkg::Q30_HALF)) >>> 30;
    wx = 37'(rx) + 37'(carry_r[N+6].px);
    wy = 37'(ry) + 37'(carry_r[N+6].py);
    sat_x = (wx > 37'sd2147483647) || (wx < -37'sd2147483648);
    sat_y = (wy > 37'sd2147483647) || (wy < -37'sd2147483648);
    if (wx > 37'sd2147483647) wx_c = 32'sh7fffffff;
    else if (wx < -37'sd2147483648) wx_c = 32'sh80000000;
    else wx_c = 32'(wx);
    if (wy > 37'sd2147483647) wy_c = 32'sh7fffffff;
    else if (wy < -37'sd2147483648) wy_c = 32'sh80000000;
    else wy_c = 32'(wy);
  end

  // Register the result
  always_ff @(posedge clk) begin
    out_world_x   <= wx_c;
    out_world_y   <= wy_c;
    out_world_z   <= fh_r;
    out_saturated <= sat_x || sat_y;
  end

  assign out_valid = v_r[LAT-1];

  `EPPT_ASSERT_IMPL(a_fold_range, v_r[0], (cz_r[0][0] <= CW'(eppt_pkg::Q30_HALF_PI)) && (cz_r[0][0] >= -CW'(eppt_pkg::Q30_HALF_PI)))
  `EPPT_ASSERT_IMPL(a_cordic_conv, v_r[N], (cz_r[N][2] <= ZB) && (cz_r[N][2] >= -ZB))
  `EPPT_ASSERT_IMPL(a_sat_flag, out_valid && out_saturated, (out_world_x == 32'sh7fffffff) || (out_world_x == 32'sh80000000) || (out_world_y == 32'sh7fffffff) || (out_world_y == 32'sh80000000))
  `EPPT_ASSERT_IMPL(a_latency, out_valid, $past(start, LAT))

endmodule
